>>> rtl/rqnt_pkg.sv
`default_nettype none

package rqnt_pkg;

  // lane count of one group
  localparam int unsigned NUM_LANES = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd3;

  localparam int unsigned CFG_DATA_W = 30;

  // scale limits and float layout
  localparam logic [CFG_DATA_W-1:0] SCALE_LO = 30'h2F80_0000;
  localparam logic [CFG_DATA_W-1:0] SCALE_HI = 30'h3F7F_FFFF;
  localparam int unsigned MANT_BITS  = 23;
  localparam int unsigned MULT_W     = MANT_BITS + 1;
  localparam int unsigned SHIFT_W    = 6;
  localparam logic [7:0]  SHIFT_BASE = 8'd150;

  // reset values (scale 0.5)
  localparam logic [MULT_W-1:0]  MULT_RST     = 24'h80_0000;
  localparam logic [SHIFT_W-1:0] SHIFT_RST    = 6'd24;
  localparam logic [7:0]         ZP_RST       = 8'd0;
  localparam logic [7:0]         OUT_MIN_RST  = 8'd0;
  localparam logic [7:0]         OUT_MAX_RST  = 8'd255;

  // request payloads
  typedef struct packed {
    logic signed [31:0] acc_lane0;
    logic signed [31:0] acc_lane1;
    logic signed [31:0] acc_lane2;
    logic signed [31:0] acc_lane3;
    logic               in_last;
  } rqnt_in_t;

  typedef struct packed {
    logic [7:0] q_lane0;
    logic [7:0] q_lane1;
    logic [7:0] q_lane2;
    logic [7:0] q_lane3;
    logic       out_last;
  } rqnt_out_t;

  // derived settings shared by all lanes
  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    logic signed [9:0]  lo;
    logic signed [9:0]  hi;
    logic [7:0]         zp;
  } rqnt_cfg_t;

endpackage

`default_nettype wire

>>> rtl/rqnt_cfg.sv
`default_nettype none

module rqnt_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rqnt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rqnt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output rqnt_pkg::rqnt_cfg_t                    cfg_o
);
  import rqnt_pkg::*;

  logic [MULT_W-1:0]     mult_r, mult_nxt;
  logic [SHIFT_W-1:0]    shift_r, shift_nxt;
  logic [7:0]            zp_r, zp_nxt;
  logic [7:0]            min_r, min_nxt;
  logic [7:0]            max_r, max_nxt;
  logic [CFG_DATA_W-1:0] scale_clamped;
  logic [7:0]            shift_full;

  // clamp scale into range and split into multiplier and shift
  always_comb begin
    scale_clamped = cfg_wdata;
    if (scale_clamped < SCALE_LO) begin
      scale_clamped = SCALE_LO;
    end
    if (scale_clamped > SCALE_HI) begin
      scale_clamped = SCALE_HI;
    end
    shift_full = SHIFT_BASE - {1'b0, scale_clamped[CFG_DATA_W-1:MANT_BITS]};
  end

  // register write decode
  always_comb begin
    mult_nxt  = mult_r;
    shift_nxt = shift_r;
    zp_nxt    = zp_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE: begin
          mult_nxt  = {1'b1, scale_clamped[MANT_BITS-1:0]};
          shift_nxt = shift_full[SHIFT_W-1:0];
        end
        CFG_ZERO_POINT: zp_nxt  = cfg_wdata[7:0];
        CFG_OUT_MIN:    min_nxt = cfg_wdata[7:0];
        CFG_OUT_MAX:    max_nxt = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= MULT_RST;
      shift_r <= SHIFT_RST;
      zp_r    <= ZP_RST;
      min_r   <= OUT_MIN_RST;
      max_r   <= OUT_MAX_RST;
    end else begin
      mult_r  <= mult_nxt;
      shift_r <= shift_nxt;
      zp_r    <= zp_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // clamp bounds relative to zero point
  always_comb begin
    cfg_o.mult  = mult_r;
    cfg_o.shift = shift_r;
    cfg_o.lo    = $signed({2'b00, min_r}) - $signed({2'b00, zp_r});
    cfg_o.hi    = $signed({2'b00, max_r}) - $signed({2'b00, zp_r});
    cfg_o.zp    = zp_r;
  end

endmodule

`default_nettype wire

>>> rtl/rqnt_lane.sv
`default_nettype none

module rqnt_lane (
  input  wire logic signed [31:0]   acc,
  input  wire rqnt_pkg::rqnt_cfg_t  cfg_i,
  output logic [7:0]                q
);
  import rqnt_pkg::*;

  logic signed [24:0] mult_s;
  logic signed [56:0] prod;
  logic signed [56:0] half;
  logic signed [56:0] neg;
  logic signed [56:0] biased;
  logic signed [56:0] shifted;
  logic signed [33:0] r;
  logic signed [33:0] lo_x;
  logic signed [33:0] hi_x;
  logic signed [33:0] t_lo;
  logic signed [33:0] t_hi;

  // product, round toward nearest with ties away from zero
  always_comb begin
    mult_s  = $signed({1'b0, cfg_i.mult});
    prod    = 57'(acc) * 57'(mult_s);
    half    = 57'sd1 <<< (cfg_i.shift - 6'd1);
    neg     = $signed({56'd0, acc[31]});
    biased  = prod - neg + half;
    shifted = biased >>> cfg_i.shift;
    r       = shifted[33:0];
  end

  // clamp, upper bound wins, then add zero point
  always_comb begin
    lo_x = 34'(cfg_i.lo);
    hi_x = 34'(cfg_i.hi);
    t_lo = (r < lo_x) ? lo_x : r;
    t_hi = (t_lo > hi_x) ? hi_x : t_lo;
    q    = t_hi[7:0] + cfg_i.zp;
  end

endmodule

`default_nettype wire

>>> rtl/requantize_int32_to_u8_round_away_top.sv
// Pipeline: a group moves from the input register to the result register, where
// out_valid rises. Throughput: one group of four lanes per cycle unless out_ready
// stalls the output; a full 32x24 multiply, round, variable shift and clamp per lane
// sit between the two registers.
// Reset: both valid flags clear; scale returns to 0.5, zero point 0, bounds 0..255.
`default_nettype none

module requantize_int32_to_u8_round_away_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rqnt_pkg::rqnt_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rqnt_pkg::rqnt_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rqnt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rqnt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rqnt_pkg::*;

  rqnt_cfg_t          cfg;
  logic               s1_valid_r, s1_valid_nxt;
  rqnt_in_t           s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  rqnt_out_t          out_data_r;
  rqnt_out_t          res;
  logic               adv_out;
  logic               acc_in;
  logic signed [31:0] acc [NUM_LANES];
  logic [7:0]         q   [NUM_LANES];

  rqnt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // handshake: result register advances when empty or taken
  always_comb begin
    adv_out       = !out_valid_r || out_ready;
    in_ready      = !s1_valid_r || adv_out;
    acc_in        = in_valid && in_ready;
    s1_valid_nxt  = acc_in || (s1_valid_r && !adv_out);
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_data_r <= in_data;
    end
    if (adv_out && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  // lane datapath
  always_comb begin
    acc[0] = s1_data_r.acc_lane0;
    acc[1] = s1_data_r.acc_lane1;
    acc[2] = s1_data_r.acc_lane2;
    acc[3] = s1_data_r.acc_lane3;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rqnt_lane u_lane (
      .acc   (acc[i]),
      .cfg_i (cfg),
      .q     (q[i])
    );
  end

  always_comb begin
    res.q_lane0  = q[0];
    res.q_lane1  = q[1];
    res.q_lane2  = q[2];
    res.q_lane3  = q[3];
    res.out_last = s1_data_r.in_last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a ready consumer never stalls the input side
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // a staged request moves into the result register when it advances
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv_out) |=> out_valid)
    else $error("staged request lost");

  // an accepted request followed by out_ready passes through the input and result registers with its last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=>
      (out_valid && (out_data.out_last == $past(in_data.in_last, 2))))
    else $error("last flag mismatch");

endmodule

`default_nettype wire

>>> test/requantize_int32_to_u8_round_away_top_tb.sv
`default_nettype none

module requantize_int32_to_u8_round_away_top_tb;
  import rqnt_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 2;
  localparam int STALL_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int GROUPS_PER_BLK = 192;

  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET  = 30'h3F00_0000;
  localparam logic signed [31:0]    ACC_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0]    ACC_MAX      = 32'sh7FFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  rqnt_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rqnt_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // local copy of the register file
  logic [CFG_DATA_W-1:0] scale_q  = SCALE_RESET;
  logic [7:0]            zp_q     = ZP_RST;
  logic [7:0]            min_q    = OUT_MIN_RST;
  logic [7:0]            max_q    = OUT_MAX_RST;

  rqnt_in_t  acc_group_q[$];
  rqnt_out_t pending_bytes_q[$];

  int   in_idle_pct  = 0;
  int   out_idle_pct = 0;
  int   err_cnt      = 0;
  logic in_acc       = 1'b0;
  logic drain_req    = 1'b0;
  logic drain_used   = 1'b0;
  int   drain_cnt    = 0;

  requantize_int32_to_u8_round_away_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // one lane: multiply, bias down by one for negatives, add half, shift, clamp, offset
  function automatic logic [7:0] requant_lane(input logic signed [31:0] acc);
    longint prod, mult, lo, hi, zp;
    int     sh;
    mult = longint'({1'b1, scale_q[MANT_BITS-1:0]});
    sh   = int'(SHIFT_BASE) - int'(scale_q[CFG_DATA_W-1:MANT_BITS]);
    prod = longint'(acc);
    prod = prod * mult;
    if (acc < 0)
      prod = prod - 1;
    prod = prod + (longint'(1) << (sh - 1));
    prod = prod >>> sh;
    zp = longint'(zp_q);
    lo = longint'(min_q);
    hi = longint'(max_q);
    lo = lo - zp;
    hi = hi - zp;
    if (prod < lo)
      prod = lo;
    if (prod > hi)
      prod = hi;
    prod = prod + zp;
    return prod[7:0];
  endfunction

  function automatic rqnt_out_t requant_group(input rqnt_in_t g);
    rqnt_out_t r;
    r.q_lane0  = requant_lane(g.acc_lane0);
    r.q_lane1  = requant_lane(g.acc_lane1);
    r.q_lane2  = requant_lane(g.acc_lane2);
    r.q_lane3  = requant_lane(g.acc_lane3);
    r.out_last = g.in_last;
    return r;
  endfunction

  // accumulators spread over all magnitudes so every scale sees in-range results
  function automatic logic signed [31:0] rand_acc();
    logic [31:0] v;
    case ($urandom_range(3, 0))
      0: v = $urandom();
      1: v = $urandom() >> $urandom_range(31, 0);
      2: v = $urandom_range(600, 0);
      default: v = $urandom_range(1, 0) ? ACC_MAX : ACC_MIN;
    endcase
    if ($urandom_range(1, 0) == 1)
      v = -v;
    return v;
  endfunction

  // register write, only issued while the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SCALE: begin
        if (val < SCALE_LO)
          scale_q = SCALE_LO;
        else if (val > SCALE_HI)
          scale_q = SCALE_HI;
        else
          scale_q = val;
      end
      CFG_ZERO_POINT: zp_q = val[7:0];
      CFG_OUT_MIN:    min_q = val[7:0];
      CFG_OUT_MAX:    max_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_group(input logic signed [31:0] a0, input logic signed [31:0] a1,
                            input logic signed [31:0] a2, input logic signed [31:0] a3,
                            input logic last);
    rqnt_in_t g;
    g.acc_lane0 = a0;
    g.acc_lane1 = a1;
    g.acc_lane2 = a2;
    g.acc_lane3 = a3;
    g.in_last   = last;
    acc_group_q.push_back(g);
  endtask

  // wait until every request has gone through and every result has come back
  task automatic settle();
    while (acc_group_q.size() != 0 || in_valid || pending_bytes_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (acc_group_q.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= acc_group_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (drain_req && !drain_used) begin
      drain_used <= 1'b1;
      drain_cnt  <= STALL_CYCLES;
      out_ready  <= 1'b0;
    end else if (drain_cnt != 0) begin
      drain_cnt <= drain_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  // result check against the oldest prediction, then predict new requests
  always @(posedge clk) begin : monitor
    rqnt_out_t want;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result q=%h %h %h %h last=%b", out_data.q_lane0,
                   out_data.q_lane1, out_data.q_lane2, out_data.q_lane3, out_data.out_last);
      end else begin
        want = pending_bytes_q.pop_front();
        if (out_data.q_lane0 !== want.q_lane0 || out_data.q_lane1 !== want.q_lane1 ||
            out_data.q_lane2 !== want.q_lane2 || out_data.q_lane3 !== want.q_lane3 ||
            out_data.out_last !== want.out_last) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("result mismatch exp q=%h %h %h %h last=%b got q=%h %h %h %h last=%b",
                     want.q_lane0, want.q_lane1, want.q_lane2, want.q_lane3, want.out_last,
                     out_data.q_lane0, out_data.q_lane1, out_data.q_lane2, out_data.q_lane3,
                     out_data.out_last);
        end
      end
    end
    if (rst_n && in_valid && in_ready)
      pending_bytes_q.push_back(requant_group(in_data));
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] scale_w;
    logic [7:0]            lo_w, hi_w;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: scale one half, ties on odd accumulators, both rails
    send_group(0, 1, -1, 2, 1'b0);
    send_group(3, 511, 509, -2, 1'b1);
    send_group(ACC_MAX, ACC_MIN, 510, 511, 1'b0);
    settle();

    // scale written below range, mid zero point
    cfg_write(CFG_SCALE, 30'h0);
    cfg_write(CFG_ZERO_POINT, 30'd128);
    send_group(ACC_MIN, ACC_MAX, 0, -1, 1'b1);
    settle();

    // scale written above range, clamp at both sides of the zero point
    cfg_write(CFG_SCALE, 30'h3FFF_FFFF);
    send_group(127, -128, 128, -129, 1'b0);
    send_group(1, -1, ACC_MAX, ACC_MIN, 1'b1);
    settle();

    // inverted bounds: every lane gives the upper bound
    cfg_write(CFG_OUT_MIN, 30'd200);
    cfg_write(CFG_OUT_MAX, 30'd50);
    send_group(0, 100, -100, ACC_MAX, 1'b0);
    settle();

    // writes to unused indexes change nothing
    cfg_write(CFG_SPARE_LO, 30'h3FFF_FFFF);
    cfg_write(CFG_SPARE_HI, 30'h0);
    send_group(5, -5, 60, -60, 1'b1);
    settle();

    // scale one quarter, ties on even accumulators around the zero point
    cfg_write(CFG_OUT_MIN, 30'd0);
    cfg_write(CFG_OUT_MAX, 30'd255);
    cfg_write(CFG_SCALE, 30'h3E80_0000);
    send_group(2, -2, 6, -6, 1'b0);
    send_group(1, -1, 3, -3, 1'b1);
    settle();

    // random blocks, each with its own settings; the idling pattern changes per pair of blocks
    for (int blk = 0; blk < 6; blk++) begin
      in_idle_pct  = (blk < 2) ? 9 : (blk < 4) ? 48 : 0;
      out_idle_pct = (blk < 2) ? 48 : (blk < 4) ? 9 : 0;
      case (blk)
        0: scale_w = SCALE_LO;
        1: scale_w = SCALE_HI;
        default: begin
          scale_w = CFG_DATA_W'($urandom_range(SCALE_HI, SCALE_LO));
          if ($urandom_range(2, 0) == 0)
            scale_w[MANT_BITS-1:0] = '0;
        end
      endcase
      cfg_write(CFG_SCALE, scale_w);
      cfg_write(CFG_ZERO_POINT, CFG_DATA_W'((blk == 0) ? 8'd0 : (blk == 1) ? 8'd255 :
                                            $urandom_range(255, 0)));
      case (blk)
        0, 1: begin
          lo_w = 8'd0;
          hi_w = 8'd255;
        end
        3: begin
          lo_w = 8'($urandom_range(255, 0));
          hi_w = 8'($urandom_range(255, 0));
        end
        default: begin
          lo_w = 8'($urandom_range(120, 0));
          hi_w = 8'($urandom_range(255, 130));
        end
      endcase
      cfg_write(CFG_OUT_MIN, CFG_DATA_W'(lo_w));
      cfg_write(CFG_OUT_MAX, CFG_DATA_W'(hi_w));
      for (int n = 0; n < GROUPS_PER_BLK; n++)
        send_group(rand_acc(), rand_acc(), rand_acc(), rand_acc(), $urandom_range(7, 0) == 0);
      // long receiver hold-off while requests keep coming
      if (blk == 4)
        drain_req = 1'b1;
      settle();
    end

    repeat (8) @(negedge clk);
    if (pending_bytes_q.size() != 0)
      err_cnt++;
    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
